FILE: rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared widths, reset values, register indexes and types of the gait phase
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package gps_pkg;

   // field widths
   localparam int TIME_W   = 20;               // microsecond times
   localparam int Q_BITS   = 16;               // Q0.16 fraction bits
   localparam int PROG_W   = Q_BITS + 1;       // progress, holds 1.0
   localparam int TICK_W   = 8;
   localparam int PACK_W   = 64;               // packed per-leg fractions
   localparam int CSR_W    = PACK_W;
   localparam int CSR_IDX_W = 3;
   localparam int LEG_SLOTS = 4;
   localparam int LEG_W    = $clog2(LEG_SLOTS);
   localparam int CNT_W    = $clog2(Q_BITS);

   localparam int NUM_LEGS_DEFAULT = 4;

   // register reset values
   localparam logic [TICK_W-1:0] TICK_DIVIDE_RST  = 8'd9;
   localparam logic [TIME_W-1:0] STEP_TIME_RST    = 20'd23000;
   localparam logic [TIME_W-1:0] CYCLE_PERIOD_RST = 20'd600000;
   localparam logic [PACK_W-1:0] LEG_OFFSETS_RST  = 64'h0000_8000_8000_0000;
   localparam logic [PACK_W-1:0] LEG_RATIOS_RST   = 64'h8000_8000_8000_8000;

   localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << Q_BITS;
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(Q_BITS - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEG_OFFSETS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEG_RATIOS   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_LOCAL,
      ST_DECIDE,
      ST_DIV,
      ST_STORE,
      ST_DONE
   } state_type;

   // control of one bit-serial unit
   typedef struct packed {
      logic load;
      logic shift;
   } serial_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/gps_frac_mul.sv
// ----------------------------------------------------------------------------
// gps_frac_mul
// Bit-serial fraction multiplier: period * frac / 2^16, one fraction bit per
// cycle while shift is high, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_frac_mul (
   input  wire logic                       clock,
   input  wire gps_pkg::serial_ctl_type    ctl,
   input  wire logic [gps_pkg::TIME_W-1:0] period,
   input  wire logic [gps_pkg::Q_BITS-1:0] frac,
   output logic      [gps_pkg::TIME_W-1:0] product
);
   import gps_pkg::*;

   logic [TIME_W-1:0] acc_ff;
   logic [Q_BITS-1:0] frac_ff;
   logic [TIME_W:0]   sum;

   // acc stays below period, so the sum fits one extra bit
   assign sum = {1'b0, acc_ff} + (frac_ff[0] ? {1'b0, period} : '0);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_ff  <= '0;
         frac_ff <= frac;
      end else if (ctl.shift) begin
         acc_ff  <= sum[TIME_W:1];
         frac_ff <= frac_ff >> 1;
      end
   end

   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/gps_frac_div.sv
// ----------------------------------------------------------------------------
// gps_frac_div
// Bit-serial restoring divider: (dividend << 16) / divisor for
// dividend < divisor, one quotient bit per cycle while shift is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_frac_div (
   input  wire logic                       clock,
   input  wire gps_pkg::serial_ctl_type    ctl,
   input  wire logic [gps_pkg::TIME_W-1:0] dividend,
   input  wire logic [gps_pkg::TIME_W-1:0] divisor,
   output logic      [gps_pkg::Q_BITS-1:0] quotient
);
   import gps_pkg::*;

   logic [TIME_W-1:0] rem_ff;
   logic [Q_BITS-1:0] quo_ff;
   logic [TIME_W:0]   rem2;
   logic [TIME_W:0]   diff;
   logic              fits;

   assign rem2 = {rem_ff, 1'b0};
   assign diff = rem2 - {1'b0, divisor};
   assign fits = rem2 >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rem_ff <= dividend;
         quo_ff <= '0;
      end else if (ctl.shift) begin
         // remainder stays below divisor either way
         rem_ff <= fits ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
         quo_ff <= {quo_ff[Q_BITS-2:0], fits};
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/gait_phase_scheduler.sv
// ----------------------------------------------------------------------------
// gait_phase_scheduler
// Periodic offset gait scheduler: prescaled gait clock and per-leg stance and
// swing progress in Q0.16, one result beat per control tick.
// ----------------------------------------------------------------------------
// Each req beat is one control tick and yields exactly one rsp beat. A tick
// that does not fall on a gait update is accepted, then its result is handed
// to the output register. A gait update tick handles the legs in turn with
// one 16-step bit-serial multiplier pair (offset and stance time) and one
// 16-step bit-serial divider (progress), plus the setup states LOAD, LOCAL,
// DECIDE and STORE for each leg, before the hand-over. One tick
// is worked on at a time; req_stall is high from acceptance until the result
// has moved into the output register, which then holds it while rsp_stall is
// high. Configuration writes take effect at once and must only be issued
// while the block is idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_phase_scheduler #(
   parameter int NUM_LEGS = gps_pkg::NUM_LEGS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration port
   input  wire logic                          csr_write,
   input  wire logic [gps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gps_pkg::CSR_W-1:0]     csr_wdata,
   // tick channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_restart,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_updated,
   output logic      [gps_pkg::TIME_W-1:0]    rsp_gait_time,
   output logic      [gps_pkg::LEG_SLOTS-1:0] rsp_stance_mask,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_stance_prog_0,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_stance_prog_1,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_stance_prog_2,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_stance_prog_3,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_swing_prog_0,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_swing_prog_1,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_swing_prog_2,
   output logic      [gps_pkg::PROG_W-1:0]    rsp_swing_prog_3
);
   import gps_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [TICK_W-1:0] tick_divide_ff;
   logic [TIME_W-1:0] step_time_ff;
   logic [TIME_W-1:0] cycle_period_ff;
   logic [PACK_W-1:0] leg_offsets_ff;
   logic [PACK_W-1:0] leg_ratios_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff  <= TICK_DIVIDE_RST;
         step_time_ff    <= STEP_TIME_RST;
         cycle_period_ff <= CYCLE_PERIOD_RST;
         leg_offsets_ff  <= LEG_OFFSETS_RST;
         leg_ratios_ff   <= LEG_RATIOS_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TICK_DIVIDE:  tick_divide_ff  <= csr_wdata[TICK_W-1:0];
            CSR_STEP_TIME:    step_time_ff    <= csr_wdata[TIME_W-1:0];
            CSR_CYCLE_PERIOD: cycle_period_ff <= csr_wdata[TIME_W-1:0];
            CSR_LEG_OFFSETS:  leg_offsets_ff  <= csr_wdata[PACK_W-1:0];
            CSR_LEG_RATIOS:   leg_ratios_ff   <= csr_wdata[PACK_W-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   state_type         state_ff, state_in;
   logic [TICK_W-1:0] tick_count_ff;
   logic [TIME_W-1:0] gait_clock_ff;
   logic [LEG_SLOTS-1:0] stance_bits_ff;
   logic [PROG_W-1:0] stance_prog_ff [LEG_SLOTS];
   logic [PROG_W-1:0] swing_prog_ff  [LEG_SLOTS];
   logic              updated_ff;
   logic [LEG_W-1:0]  leg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] local_ff;
   logic              in_stance_ff;
   logic              zero_dur_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_updated_ff;
   logic [TIME_W-1:0]    rsp_gait_time_ff;
   logic [LEG_SLOTS-1:0] rsp_stance_mask_ff;
   logic [PROG_W-1:0]    rsp_stance_prog_ff [LEG_SLOTS];
   logic [PROG_W-1:0]    rsp_swing_prog_ff  [LEG_SLOTS];

   // ---------------------------------------------------------------- tick front end
   logic              accept;
   logic [TICK_W-1:0] tick_eff;
   logic [TIME_W-1:0] clock_eff;
   logic [TIME_W:0]   clock_sum;
   logic [TIME_W-1:0] clock_next;
   logic              upd_now;

   assign accept    = req_valid && !req_stall;
   // a restart clears the counters before the tick is looked at
   assign tick_eff  = req_restart ? '0 : tick_count_ff;
   assign clock_eff = req_restart ? '0 : gait_clock_ff;
   assign upd_now   = tick_eff >= tick_divide_ff;
   assign clock_sum = {1'b0, clock_eff} + {1'b0, step_time_ff};
   // reaching the period snaps the clock to zero, nothing is subtracted
   assign clock_next = (clock_sum >= {1'b0, cycle_period_ff}) ? '0
                                                              : clock_sum[TIME_W-1:0];

   // ---------------------------------------------------------------- serial units
   serial_ctl_type    mul_ctl;
   serial_ctl_type    div_ctl;
   logic [Q_BITS-1:0] off_frac;
   logic [Q_BITS-1:0] ratio_frac;
   logic [TIME_W-1:0] t_off;
   logic [TIME_W-1:0] t_st;
   logic [TIME_W-1:0] div_dividend;
   logic [TIME_W-1:0] div_divisor;
   logic [Q_BITS-1:0] div_quotient;
   logic              in_stance;

   assign off_frac   = leg_offsets_ff[leg_ff*Q_BITS +: Q_BITS];
   assign ratio_frac = leg_ratios_ff[leg_ff*Q_BITS +: Q_BITS];

   gps_frac_mul u_mul_off (
      .clock   (clock),
      .ctl     (mul_ctl),
      .period  (cycle_period_ff),
      .frac    (off_frac),
      .product (t_off)
   );

   gps_frac_mul u_mul_st (
      .clock   (clock),
      .ctl     (mul_ctl),
      .period  (cycle_period_ff),
      .frac    (ratio_frac),
      .product (t_st)
   );

   // stance: elapsed is local time over stance time; swing: time past the
   // stance phase over the rest of the period. Elapsed stays below duration.
   assign in_stance    = local_ff < t_st;
   assign div_dividend = in_stance ? local_ff : local_ff - t_st;
   assign div_divisor  = in_stance ? t_st : cycle_period_ff - t_st;

   gps_frac_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------- sequencer
   logic last_leg;
   logic rsp_capture;

   assign last_leg = leg_ff == LEG_W'(NUM_LEGS - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = upd_now ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD:   state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_LOCAL;
            end
         end
         ST_LOCAL:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE:  state_in = last_leg ? ST_DONE : ST_LOAD;
         ST_DONE: begin
            if (rsp_capture) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_ctl.load  = state_ff == ST_LOAD;
      mul_ctl.shift = state_ff == ST_MUL;
      div_ctl.load  = state_ff == ST_DECIDE;
      div_ctl.shift = state_ff == ST_DIV;
      req_stall     = state_ff != ST_IDLE;
      // hand over once the output register is free or being drained
      rsp_capture   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // ---------------------------------------------------------------- datapath
   logic [TIME_W:0] wrapped;

   // clock behind the offset wraps forward by one period
   assign wrapped = {1'b0, gait_clock_ff} + {1'b0, cycle_period_ff} - {1'b0, t_off};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_count_ff  <= '0;
         gait_clock_ff  <= '0;
         stance_bits_ff <= '1;
         for (int k = 0; k < LEG_SLOTS; k++) begin
            stance_prog_ff[k] <= PROG_ONE;
            swing_prog_ff[k]  <= '0;
         end
         updated_ff <= 1'b0;
         leg_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_restart) begin
                     stance_bits_ff <= '1;
                     for (int k = 0; k < LEG_SLOTS; k++) begin
                        stance_prog_ff[k] <= PROG_ONE;
                        swing_prog_ff[k]  <= '0;
                     end
                  end
                  tick_count_ff <= upd_now ? '0 : TICK_W'(tick_eff + 1'b1);
                  gait_clock_ff <= upd_now ? clock_next : clock_eff;
                  updated_ff    <= upd_now;
                  leg_ff        <= '0;
               end
            end
            ST_LOAD: cnt_ff <= CNT_LAST;
            ST_MUL:  cnt_ff <= cnt_ff - 1'b1;
            ST_LOCAL: begin
               local_ff <= (gait_clock_ff < t_off) ? wrapped[TIME_W-1:0]
                                                   : gait_clock_ff - t_off;
            end
            ST_DECIDE: begin
               cnt_ff       <= CNT_LAST;
               in_stance_ff <= in_stance;
               zero_dur_ff  <= div_divisor == '0;
            end
            ST_DIV:  cnt_ff <= cnt_ff - 1'b1;
            ST_STORE: begin
               stance_bits_ff[leg_ff] <= in_stance_ff;
               if (in_stance_ff) begin
                  stance_prog_ff[leg_ff] <= zero_dur_ff ? '0 : {1'b0, div_quotient};
                  swing_prog_ff[leg_ff]  <= '0;
               end else begin
                  stance_prog_ff[leg_ff] <= '0;
                  swing_prog_ff[leg_ff]  <= zero_dur_ff ? '0 : {1'b0, div_quotient};
               end
               leg_ff <= leg_ff + 1'b1;
            end
            default: begin
               // hold
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_capture) begin
         rsp_updated_ff     <= updated_ff;
         rsp_gait_time_ff   <= gait_clock_ff;
         rsp_stance_mask_ff <= stance_bits_ff;
         for (int k = 0; k < LEG_SLOTS; k++) begin
            rsp_stance_prog_ff[k] <= stance_prog_ff[k];
            rsp_swing_prog_ff[k]  <= swing_prog_ff[k];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_updated       = rsp_updated_ff;
   assign rsp_gait_time     = rsp_gait_time_ff;
   assign rsp_stance_mask   = rsp_stance_mask_ff;
   assign rsp_stance_prog_0 = rsp_stance_prog_ff[0];
   assign rsp_stance_prog_1 = rsp_stance_prog_ff[1];
   assign rsp_stance_prog_2 = rsp_stance_prog_ff[2];
   assign rsp_stance_prog_3 = rsp_stance_prog_ff[3];
   assign rsp_swing_prog_0  = rsp_swing_prog_ff[0];
   assign rsp_swing_prog_1  = rsp_swing_prog_ff[1];
   assign rsp_swing_prog_2  = rsp_swing_prog_ff[2];
   assign rsp_swing_prog_3  = rsp_swing_prog_ff[3];

   // ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
   // an update tick goes straight into the leg sequence
   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      accept && upd_now |=> state_ff == ST_LOAD)
      else $error("update tick did not start the leg sequence");

   // the divider only ever sees a proper fraction, or a zero duration
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      div_ctl.load |-> (div_dividend < div_divisor || div_divisor == '0))
      else $error("divider loaded with dividend not below divisor");

   // offset time and clock lie inside the cycle when the local time is formed
   a_local_inputs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOCAL |->
         ((t_off < cycle_period_ff && gait_clock_ff < cycle_period_ff) ||
          cycle_period_ff == '0))
      else $error("offset time or gait clock outside the cycle");

   // the leg counter never walks past the last configured leg
   a_leg_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE && !last_leg |=> leg_ff <= LEG_W'(NUM_LEGS - 1))
      else $error("leg counter beyond configured legs");
`endif

endmodule

`default_nettype wire

FILE: test/gait_phase_scheduler_tb.sv
// ----------------------------------------------------------------------------
// gait_phase_scheduler_tb
// Self-checking bench for the gait phase scheduler. It sends control ticks
// over the req channel and keeps a cycle-free model of the prescaler, gait
// clock and leg phases. Each tick adds one expected rsp beat, and each rsp
// beat is checked field by field against the oldest one. A directed opening
// covers restart, the extremes of every register, a lowered period, a lowered
// divider and a zero period. Random phases with new register settings follow.
// Random idle and stall bursts fall on both channels until the final stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_phase_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gps_pkg::*;

   localparam int NUM_LEGS     = 4;
   localparam int DIRECTED     = 25;
   localparam int RANDOM_TICKS = 400;
   // stop idling and stalling for the last part of the run
   localparam int CALM_AFTER   = DIRECTED + RANDOM_TICKS - 60;

   // one rsp beat as the block presents it
   typedef struct packed {
      logic                             updated;
      logic [TIME_W-1:0]                gait_time;
      logic [LEG_SLOTS-1:0]             stance_mask;
      logic [LEG_SLOTS-1:0][PROG_W-1:0] stance_prog;
      logic [LEG_SLOTS-1:0][PROG_W-1:0] swing_prog;
   } gait_beat_t;

   // -------------------------------------------------------------------------
   // Gait model: register copies, leg state and the queue of pending beats.
   // -------------------------------------------------------------------------
   class phase_scoreboard;
      logic [TICK_W-1:0] tick_divide;
      logic [TIME_W-1:0] step_time;
      logic [TIME_W-1:0] cycle_period;
      logic [PACK_W-1:0] leg_offsets;
      logic [PACK_W-1:0] leg_ratios;

      logic [TICK_W-1:0]    tick_count;
      logic [31:0]          gait_clock;
      logic [LEG_SLOTS-1:0] stance_bits;
      logic [PROG_W-1:0]    stance_prog [LEG_SLOTS];
      logic [PROG_W-1:0]    swing_prog [LEG_SLOTS];

      gait_beat_t expected_phases[$];
      int         errors;

      function new();
         tick_divide  = TICK_DIVIDE_RST;
         step_time    = STEP_TIME_RST;
         cycle_period = CYCLE_PERIOD_RST;
         leg_offsets  = LEG_OFFSETS_RST;
         leg_ratios   = LEG_RATIOS_RST;
         errors       = 0;
         restart_gait();
      endfunction

      function void restart_gait();
         tick_count  = '0;
         gait_clock  = '0;
         stance_bits = '1;
         for (int k = 0; k < LEG_SLOTS; k++) begin
            stance_prog[k] = PROG_ONE;
            swing_prog[k]  = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_TICK_DIVIDE:  tick_divide  = data[TICK_W-1:0];
            CSR_STEP_TIME:    step_time    = data[TIME_W-1:0];
            CSR_CYCLE_PERIOD: cycle_period = data[TIME_W-1:0];
            CSR_LEG_OFFSETS:  leg_offsets  = data;
            CSR_LEG_RATIOS:   leg_ratios   = data;
            default: ;
         endcase
      endfunction

      // floor(period * frac / 2^16)
      function logic [31:0] share_of(logic [31:0] period, logic [Q_BITS-1:0] frac);
         logic [63:0] prod;
         prod = 64'(period) * 64'(frac);
         return prod[47:16];
      endfunction

      // floor(elapsed * 2^16 / span), zero span gives zero, capped at one
      function logic [PROG_W-1:0] q16_progress(logic [31:0] elapsed, logic [31:0] span);
         logic [63:0] q;
         if (span == 0) return '0;
         q = (64'(elapsed) << Q_BITS) / 64'(span);
         return (q > 64'(PROG_ONE)) ? PROG_ONE : q[PROG_W-1:0];
      endfunction

      function void advance_gait();
         logic [31:0] period;
         logic [31:0] sum;
         logic [31:0] t_off;
         logic [31:0] t_st;
         logic [31:0] t_sw;
         logic [31:0] elapsed;
         period = 32'(cycle_period);
         sum    = gait_clock + 32'(step_time);
         gait_clock = (sum >= period) ? 32'd0 : sum;
         for (int leg = 0; leg < NUM_LEGS; leg++) begin
            t_off = share_of(period, leg_offsets[16*leg +: 16]);
            t_st  = share_of(period, leg_ratios[16*leg +: 16]);
            t_sw  = period - t_st;
            if (gait_clock < t_off) elapsed = gait_clock + period - t_off;
            else elapsed = gait_clock - t_off;
            if (elapsed < t_st) begin
               stance_bits[leg] = 1'b1;
               stance_prog[leg] = q16_progress(elapsed, t_st);
               swing_prog[leg]  = '0;
            end else begin
               stance_bits[leg] = 1'b0;
               stance_prog[leg] = '0;
               swing_prog[leg]  = q16_progress(elapsed - t_st, t_sw);
            end
         end
      endfunction

      function void note_tick(logic restart);
         gait_beat_t beat;
         if (restart) restart_gait();
         if (tick_count >= tick_divide) begin
            tick_count   = '0;
            beat.updated = 1'b1;
            advance_gait();
         end else begin
            tick_count   = tick_count + 1'b1;
            beat.updated = 1'b0;
         end
         beat.gait_time   = gait_clock[TIME_W-1:0];
         beat.stance_mask = stance_bits;
         for (int k = 0; k < LEG_SLOTS; k++) begin
            beat.stance_prog[k] = stance_prog[k];
            beat.swing_prog[k]  = swing_prog[k];
         end
         expected_phases.push_back(beat);
      endfunction

      function void match_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(gait_beat_t got);
         gait_beat_t want;
         if (expected_phases.size() == 0) begin
            $display("%0t unexpected rsp beat: expected none, actual gait_time %0d",
                     $time, got.gait_time);
            errors++;
            return;
         end
         want = expected_phases.pop_front();
         match_field("updated", 32'(want.updated), 32'(got.updated));
         match_field("gait_time", 32'(want.gait_time), 32'(got.gait_time));
         match_field("stance_mask", 32'(want.stance_mask), 32'(got.stance_mask));
         for (int k = 0; k < LEG_SLOTS; k++) begin
            match_field($sformatf("stance_prog_%0d", k),
                        32'(want.stance_prog[k]), 32'(got.stance_prog[k]));
            match_field($sformatf("swing_prog_%0d", k),
                        32'(want.swing_prog[k]), 32'(got.swing_prog[k]));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TICK_DIVIDE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   logic req_valid   = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_stall   = 1'b0;

   wire logic                 req_stall;
   wire logic                 rsp_valid;
   wire logic                 rsp_updated;
   wire logic [TIME_W-1:0]    rsp_gait_time;
   wire logic [LEG_SLOTS-1:0] rsp_stance_mask;
   wire logic [PROG_W-1:0]    rsp_stance_prog_0, rsp_stance_prog_1;
   wire logic [PROG_W-1:0]    rsp_stance_prog_2, rsp_stance_prog_3;
   wire logic [PROG_W-1:0]    rsp_swing_prog_0, rsp_swing_prog_1;
   wire logic [PROG_W-1:0]    rsp_swing_prog_2, rsp_swing_prog_3;

   phase_scoreboard sb;
   int ticks_sent = 0;
   bit calm = 1'b0;     // set once idling and stalling should stop

   always #6 clock = ~clock;

   gait_phase_scheduler #(
      .NUM_LEGS(NUM_LEGS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_updated       (rsp_updated),
      .rsp_gait_time     (rsp_gait_time),
      .rsp_stance_mask   (rsp_stance_mask),
      .rsp_stance_prog_0 (rsp_stance_prog_0),
      .rsp_stance_prog_1 (rsp_stance_prog_1),
      .rsp_stance_prog_2 (rsp_stance_prog_2),
      .rsp_stance_prog_3 (rsp_stance_prog_3),
      .rsp_swing_prog_0  (rsp_swing_prog_0),
      .rsp_swing_prog_1  (rsp_swing_prog_1),
      .rsp_swing_prog_2  (rsp_swing_prog_2),
      .rsp_swing_prog_3  (rsp_swing_prog_3)
   );

   // -------------------------------------------------------------------------
   // Driver tasks. All drives happen by NBA right after a rising edge, so the
   // block samples them at the next edge without any ordering race.
   // -------------------------------------------------------------------------

   // Write one register; the block must be idle. Mirror it into the model.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Send one tick beat. Valid stays high from one beat to the next unless an
   // idle burst is inserted first; the payload holds while stalled.
   task automatic send_tick(input logic restart);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: predict its result beat
      sb.note_tick(restart);
      ticks_sent++;
      calm = (ticks_sent >= CALM_AFTER);
   endtask

   // Drop valid and wait until every predicted beat has come back, plus a
   // short margin, so the next register writes hit an idle block.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_phases.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One random phase: a fresh mix of register values, then a run of ticks
   // with occasional restarts. Extremes come up often on purpose.
   task automatic random_phase(input bit write_all);
      logic [CSR_W-1:0] v;
      int               n;
      if (write_all || $urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 7))
            0:       v = 64'd0;
            1:       v = 64'd255;
            2:       v = 64'($urandom_range(0, 255));
            default: v = 64'($urandom_range(0, 6));
         endcase
         write_csr(CSR_TICK_DIVIDE, v);
      end
      if (write_all || $urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 7))
            0:       v = 64'd1;
            1:       v = 64'hF_FFFF;
            2:       v = 64'($urandom_range(1, 1000));
            default: v = 64'($urandom_range(1000, 20'hF_FFFF));
         endcase
         write_csr(CSR_CYCLE_PERIOD, v);
      end
      if (write_all || $urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 7))
            0:       v = 64'd0;
            1:       v = 64'hF_FFFF;
            2:       v = 64'($urandom_range(0, 20'hF_FFFF));
            default: v = 64'($urandom_range(0, 32'(sb.cycle_period) / 4));
         endcase
         write_csr(CSR_STEP_TIME, v);
      end
      // packed fractions: per leg pick zero, max, one half or anything
      if (write_all || $urandom_range(0, 1) == 1) begin
         for (int leg = 0; leg < LEG_SLOTS; leg++) begin
            case ($urandom_range(0, 5))
               0:       v[16*leg +: 16] = 16'h0000;
               1:       v[16*leg +: 16] = 16'hFFFF;
               2:       v[16*leg +: 16] = 16'h8000;
               default: v[16*leg +: 16] = 16'($urandom);
            endcase
         end
         write_csr(CSR_LEG_OFFSETS, v);
      end
      if (write_all || $urandom_range(0, 1) == 1) begin
         for (int leg = 0; leg < LEG_SLOTS; leg++) begin
            case ($urandom_range(0, 5))
               0:       v[16*leg +: 16] = 16'h0000;
               1:       v[16*leg +: 16] = 16'hFFFF;
               2:       v[16*leg +: 16] = 16'h8000;
               default: v[16*leg +: 16] = 16'($urandom);
            endcase
         end
         write_csr(CSR_LEG_RATIOS, v);
      end
      n = $urandom_range(15, 45);
      repeat (n) send_tick($urandom_range(0, 15) == 0);
      settle();
   endtask

   // -------------------------------------------------------------------------
   // Result sink: check every accepted rsp beat, and stall in random bursts.
   // Outputs are read right after the edge, i.e. the values the edge saw.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int         hold;
      gait_beat_t got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.updated        = rsp_updated;
            got.gait_time      = rsp_gait_time;
            got.stance_mask    = rsp_stance_mask;
            got.stance_prog[0] = rsp_stance_prog_0;
            got.stance_prog[1] = rsp_stance_prog_1;
            got.stance_prog[2] = rsp_stance_prog_2;
            got.stance_prog[3] = rsp_stance_prog_3;
            got.swing_prog[0]  = rsp_swing_prog_0;
            got.swing_prog[1]  = rsp_swing_prog_1;
            got.swing_prog[2]  = rsp_swing_prog_2;
            got.swing_prog[3]  = rsp_swing_prog_3;
            sb.check_result(got);
         end
         if (hold > 0) hold--;
         else if (!calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 5);
         rsp_stall <= (hold > 0);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus: directed opening, random phases, then drain and verdict.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      bit first;
      int waited;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: restart on the first tick, the tenth tick makes the
      // first update, then a restart puts every leg back to its reset state.
      send_tick(1'b1);
      repeat (10) send_tick(1'b0);
      send_tick(1'b1);
      settle();

      // Update on every tick with step equal to the longest period: the sum
      // reaches the period at once and the clock goes to zero. Fractions at
      // their extremes, one half and the smallest step.
      write_csr(CSR_TICK_DIVIDE, 64'd0);
      write_csr(CSR_STEP_TIME, 64'hF_FFFF);
      write_csr(CSR_CYCLE_PERIOD, 64'hF_FFFF);
      write_csr(CSR_LEG_OFFSETS, 64'hFFFF_0000_8000_0001);
      write_csr(CSR_LEG_RATIOS, 64'h0000_FFFF_0001_8000);
      repeat (2) send_tick(1'b0);
      settle();

      // Walk the clock through the long cycle, then lower the period below
      // the clock: the next update must land on zero.
      write_csr(CSR_STEP_TIME, 64'd250000);
      repeat (3) send_tick(1'b0);
      settle();
      write_csr(CSR_CYCLE_PERIOD, 64'd300000);
      send_tick(1'b0);
      settle();

      // Shortest period, then a zero period: every leg in swing at zero.
      write_csr(CSR_CYCLE_PERIOD, 64'd1);
      write_csr(CSR_STEP_TIME, 64'd0);
      send_tick(1'b0);
      settle();
      write_csr(CSR_CYCLE_PERIOD, 64'd0);
      repeat (2) send_tick(1'b0);
      settle();

      // Largest divider for a few ticks, then lower it: the next tick updates.
      write_csr(CSR_TICK_DIVIDE, 64'd255);
      write_csr(CSR_CYCLE_PERIOD, 64'd600000);
      write_csr(CSR_STEP_TIME, 64'd23000);
      repeat (3) send_tick(1'b0);
      settle();
      write_csr(CSR_TICK_DIVIDE, 64'd0);
      send_tick(1'b0);
      settle();

      // Random phases until the tick budget is spent.
      first = 1'b1;
      while (ticks_sent < DIRECTED + RANDOM_TICKS) begin
         random_phase(first);
         first = 1'b0;
      end

      // Drain, then keep waiting for any stray beats before the verdict.
      req_valid <= 1'b0;
      waited = 0;
      while (sb.expected_phases.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (160) @(posedge clock);
      if (sb.expected_phases.size() != 0) begin
         $display("%0t missing rsp beats: expected 0 pending, actual %0d",
                  $time, sb.expected_phases.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #(20_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/gps_pkg.sv
rtl/gps_frac_mul.sv
rtl/gps_frac_div.sv
rtl/gait_phase_scheduler.sv
test/gait_phase_scheduler_tb.sv
